@@ hdl/alsd_pkg.sv @@
package alsd_pkg;

    localparam int DEFAULT_MAX_LEDS = 256;

    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ALL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;

    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 16;
    localparam logic [REG_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LATCH      = 3'd5;

    localparam logic [8:0]  RST_LED_COUNT = 9'd0;
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd3;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd9;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd9;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd3;
    localparam logic [15:0] RST_LATCH     = 16'd2800;

    localparam logic [4:0] FIRST_BIT = 5'd23;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_ACCEPT,
        ST_EXEC,
        ST_FILL,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } phase_t;

endpackage

@@ hdl/addressable_led_strip_driver.sv @@
// Addressable LED strip driver, one-wire GRB transmitter with a pixel store.
// Input stream: s_axis_tuser carries the command (set pixel, set all, read
// pixel, start frame, tick); s_axis_tdata carries index and color. Every
// transaction yields exactly one result on the output stream: line level,
// busy flag and read color in m_axis_tdata, frame_done on m_axis_tlast.
// Registers are written through cfg_we/cfg_index/cfg_data by the user,
// between items; the block does not enforce it. One item runs at a time:
//   set pixel, tick, start with no memory access: accept, then execute
//   read pixel, start or tick that loads the next pixel: accept, execute,
//     then a read or load step for the synchronous read of the single store
//   set all: accept, execute, then one store write per cycle per used pixel
// Results sit in an output register; the next item is taken while a result
// waits, and processing stalls only when a new result needs that register.
// After reset a pass over all MAX_LEDS entries clears the store, while
// s_axis_tready stays low; register writes are taken during the pass.
module addressable_led_strip_driver
    import alsd_pkg::*;
#(
    parameter int MAX_LEDS = DEFAULT_MAX_LEDS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [REG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [31:0]           s_axis_tdata,
    // cmd[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // line_level[0], busy_res[1], read_red[9:2], read_green[17:10],
    // read_blue[25:18], zero[31:26]
    output logic [31:0]           m_axis_tdata,
    // frame_done
    output logic                  m_axis_tlast
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NW = ($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9;

    state_t state_reg, state_next;

    logic [8:0]  led_count_reg;
    logic [7:0]  zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [15:0] latch_reg;

    logic [CMD_W-1:0] cmd_reg;
    logic [7:0] idx_reg, red_reg, green_reg, blue_reg;

    phase_t      phase_reg, phase_next;
    logic [8:0]  led_pos_reg, led_pos_next;
    logic [4:0]  bit_pos_reg, bit_pos_next;
    logic [15:0] tick_reg, tick_next;
    logic [23:0] shift_reg, shift_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [8:0]    fill_reg, fill_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_level_reg, out_level_next;
    logic        out_busy_reg, out_busy_next;
    logic        out_done_reg, out_done_next;
    logic [23:0] out_rgb_reg, out_rgb_next;

    logic [23:0]   mem [MAX_LEDS];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0]   mem_wdata;
    logic [23:0]   mem_rdata_reg;

    logic [8:0]  n_use;
    logic        out_free, idx_ok, cur_bit, step_done, fill_last, clr_last;
    logic        load_req, read_req, fill_req;
    logic [7:0]  dur8;
    logic [16:0] tick_inc;
    logic [8:0]  led_inc;
    logic [23:0] colour;
    logic        level_now, busy_now;

    assign n_use = (NW'(led_count_reg) < NW'(MAX_LEDS)) ? led_count_reg : 9'(MAX_LEDS);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign idx_ok    = {1'b0, idx_reg} < n_use;
    assign cur_bit   = shift_reg[bit_pos_reg];
    assign tick_inc  = {1'b0, tick_reg} + 17'd1;
    assign led_inc   = led_pos_reg + 9'd1;
    assign colour    = {red_reg, green_reg, blue_reg};
    assign level_now = (phase_reg == PH_HIGH);
    assign busy_now  = (phase_reg != PH_IDLE);
    assign fill_last = (fill_reg == n_use - 9'd1);
    assign clr_last  = (clr_reg == AW'(MAX_LEDS - 1));

    always_comb
    begin
        dur8 = 8'd0;
        unique case (phase_reg)
            PH_HIGH: dur8 = cur_bit ? one_high_reg : zero_high_reg;
            PH_LOW:  dur8 = cur_bit ? one_low_reg : zero_low_reg;
            default: dur8 = 8'd0;
        endcase
        if (phase_reg == PH_LATCH)
        begin
            step_done = tick_inc >= {1'b0, (latch_reg == 16'd0) ? 16'd1 : latch_reg};
        end
        else
        begin
            step_done = tick_inc >= {9'd0, (dur8 == 8'd0) ? 8'd1 : dur8};
        end
    end

    assign load_req = ((cmd_reg == CMD_START) && (phase_reg == PH_IDLE) && (n_use != 9'd0))
                   || ((cmd_reg == CMD_TICK) && (phase_reg == PH_LOW) && step_done
                       && (bit_pos_reg == 5'd0) && (led_inc < n_use));
    assign read_req = (cmd_reg == CMD_READ) && idx_ok;
    assign fill_req = (cmd_reg == CMD_SET_ALL) && (n_use != 9'd0);

    assign s_axis_tready = (state_reg == ST_ACCEPT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_ACCEPT:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    priority if (load_req)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (read_req)
                    begin
                        state_next = ST_READ;
                    end
                    else if (fill_req)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_READ, ST_LOAD:
            begin
                state_next = ST_ACCEPT;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        led_pos_next   = led_pos_reg;
        bit_pos_next   = bit_pos_reg;
        tick_next      = tick_reg;
        shift_next     = shift_reg;
        clr_next       = clr_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_level_next = out_level_reg;
        out_busy_next  = out_busy_reg;
        out_done_next  = out_done_reg;
        out_rgb_next   = out_rgb_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(idx_reg);
        mem_wdata      = colour;
        mem_re         = 1'b0;
        mem_raddr      = AW'(idx_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 24'd0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_now;
                    out_busy_next  = busy_now;
                    out_done_next  = 1'b0;
                    out_rgb_next   = 24'd0;
                    unique case (cmd_reg)
                        CMD_SET_PIXEL:
                        begin
                            mem_we = idx_ok;
                        end
                        CMD_SET_ALL:
                        begin
                            fill_next      = 9'd0;
                            out_valid_next = !fill_req;
                        end
                        CMD_READ:
                        begin
                            mem_re         = read_req;
                            out_valid_next = !read_req;
                        end
                        CMD_START:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                led_pos_next = 9'd0;
                                if (n_use == 9'd0)
                                begin
                                    tick_next      = 16'd0;
                                    phase_next     = PH_LATCH;
                                    out_level_next = 1'b0;
                                    out_busy_next  = 1'b1;
                                end
                                else
                                begin
                                    mem_re         = 1'b1;
                                    mem_raddr      = AW'(0);
                                    out_valid_next = 1'b0;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            out_level_next = level_now;
                            tick_next      = tick_inc[15:0];
                            unique case (phase_reg)
                                PH_HIGH:
                                begin
                                    if (step_done)
                                    begin
                                        tick_next  = 16'd0;
                                        phase_next = PH_LOW;
                                    end
                                end
                                PH_LOW:
                                begin
                                    if (step_done)
                                    begin
                                        tick_next = 16'd0;
                                        if (bit_pos_reg != 5'd0)
                                        begin
                                            bit_pos_next = bit_pos_reg - 5'd1;
                                            phase_next   = PH_HIGH;
                                        end
                                        else
                                        begin
                                            led_pos_next = led_inc;
                                            if (led_inc < n_use)
                                            begin
                                                mem_re         = 1'b1;
                                                mem_raddr      = AW'(led_inc);
                                                out_valid_next = 1'b0;
                                            end
                                            else
                                            begin
                                                phase_next = PH_LATCH;
                                            end
                                        end
                                    end
                                end
                                PH_LATCH:
                                begin
                                    if (step_done)
                                    begin
                                        tick_next     = 16'd0;
                                        led_pos_next  = 9'd0;
                                        bit_pos_next  = 5'd0;
                                        phase_next    = PH_IDLE;
                                        out_done_next = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    tick_next = tick_reg;
                                end
                            endcase
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(fill_reg);
                fill_next = fill_reg + 9'd1;
                if (fill_last)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_now;
                    out_busy_next  = busy_now;
                    out_done_next  = 1'b0;
                    out_rgb_next   = 24'd0;
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_level_next = level_now;
                out_busy_next  = busy_now;
                out_done_next  = 1'b0;
                out_rgb_next   = mem_rdata_reg;
            end
            ST_LOAD:
            begin
                shift_next     = {mem_rdata_reg[15:8], mem_rdata_reg[23:16], mem_rdata_reg[7:0]};
                bit_pos_next   = FIRST_BIT;
                tick_next      = 16'd0;
                phase_next     = PH_HIGH;
                out_valid_next = 1'b1;
                out_level_next = (cmd_reg == CMD_START);
                out_busy_next  = 1'b1;
                out_done_next  = 1'b0;
                out_rgb_next   = 24'd0;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= s_axis_tuser;
            idx_reg   <= s_axis_tdata[7:0];
            red_reg   <= s_axis_tdata[15:8];
            green_reg <= s_axis_tdata[23:16];
            blue_reg  <= s_axis_tdata[31:24];
        end
        out_level_reg <= out_level_next;
        out_busy_reg  <= out_busy_next;
        out_done_reg  <= out_done_next;
        out_rgb_reg   <= out_rgb_next;
        fill_reg      <= fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= RST_LED_COUNT;
            zero_high_reg <= RST_ZERO_HIGH;
            zero_low_reg  <= RST_ZERO_LOW;
            one_high_reg  <= RST_ONE_HIGH;
            one_low_reg   <= RST_ONE_LOW;
            latch_reg     <= RST_LATCH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LED_COUNT: led_count_reg <= cfg_data[8:0];
                REG_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                REG_ZERO_LOW:  zero_low_reg  <= cfg_data[7:0];
                REG_ONE_HIGH:  one_high_reg  <= cfg_data[7:0];
                REG_ONE_LOW:   one_low_reg   <= cfg_data[7:0];
                REG_LATCH:     latch_reg     <= cfg_data;
                default:       latch_reg     <= latch_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_IDLE;
            led_pos_reg   <= 9'd0;
            bit_pos_reg   <= 5'd0;
            tick_reg      <= 16'd0;
            shift_reg     <= 24'd0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            led_pos_reg   <= led_pos_next;
            bit_pos_reg   <= bit_pos_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tdata  = {6'd0, out_rgb_reg[7:0], out_rgb_reg[15:8], out_rgb_reg[23:16],
                            out_busy_reg, out_level_reg};

endmodule

@@ bench/tb_addressable_led_strip_driver.sv @@
`timescale 1ns / 100ps

module tb_addressable_led_strip_driver;
    import alsd_pkg::*;

    localparam int MAX_PIXELS = DEFAULT_MAX_LEDS;
    localparam int IDLE_PCT = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_TICK + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST = '1;

    typedef struct packed {
        logic       level;
        logic       busy;
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } strip_out_t;

    class led_strip_scoreboard;
        logic [23:0] pixels [MAX_PIXELS];
        logic [8:0]  led_pos;
        logic [4:0]  bit_pos;
        logic [15:0] tick_cnt;
        phase_t      phase;
        logic [23:0] shift_grb;
        logic [8:0]  led_count;
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [15:0] latch_len;
        strip_out_t  pending_outputs [$];
        int          errors;

        function new();
            foreach (pixels[i])
                pixels[i] = '0;
            led_pos   = '0;
            bit_pos   = '0;
            tick_cnt  = '0;
            phase     = PH_IDLE;
            shift_grb = '0;
            led_count = RST_LED_COUNT;
            zero_high = RST_ZERO_HIGH;
            zero_low  = RST_ZERO_LOW;
            one_high  = RST_ONE_HIGH;
            one_low   = RST_ONE_LOW;
            latch_len = RST_LATCH;
            errors    = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] value);
            case (idx)
                REG_LED_COUNT: led_count = value[8:0];
                REG_ZERO_HIGH: zero_high = value[7:0];
                REG_ZERO_LOW:  zero_low  = value[7:0];
                REG_ONE_HIGH:  one_high  = value[7:0];
                REG_ONE_LOW:   one_low   = value[7:0];
                REG_LATCH:     latch_len = value;
                default: ;
            endcase
        endfunction

        function int leds_used();
            return (led_count > MAX_PIXELS) ? MAX_PIXELS : int'(led_count);
        endfunction

        function int floor_one(int v);
            return (v == 0) ? 1 : v;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        function void load_pixel();
            logic [23:0] rgb;
            rgb       = pixels[led_pos[7:0]];
            shift_grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
            bit_pos   = FIRST_BIT;
            tick_cnt  = '0;
            phase     = PH_HIGH;
        endfunction

        function void accept_command(logic [CMD_W-1:0] cmd, logic [7:0] idx,
                                     logic [7:0] r, logic [7:0] g, logic [7:0] b);
            strip_out_t want;
            phase_t     prior;
            int         n;
            int         dur;
            logic       bit_val;
            n          = leds_used();
            prior      = phase;
            want       = '0;
            want.level = (phase == PH_HIGH);
            case (cmd)
                CMD_SET_PIXEL:
                    if (idx < n)
                        pixels[idx] = {r, g, b};
                CMD_SET_ALL:
                    for (int i = 0; i < n; i++)
                        pixels[i] = {r, g, b};
                CMD_READ:
                    if (idx < n)
                        {want.red, want.green, want.blue} = pixels[idx];
                CMD_START:
                begin
                    if (phase == PH_IDLE)
                    begin
                        led_pos = '0;
                        if (n == 0)
                        begin
                            tick_cnt = '0;
                            phase    = PH_LATCH;
                        end
                        else
                            load_pixel();
                    end
                    want.level = (phase == PH_HIGH);
                end
                CMD_TICK:
                begin
                    bit_val    = shift_grb[bit_pos];
                    want.level = 1'b0;
                    case (phase)
                        PH_HIGH:
                        begin
                            dur        = floor_one(int'(bit_val ? one_high : zero_high));
                            want.level = 1'b1;
                            tick_cnt++;
                            if (tick_cnt >= dur)
                            begin
                                tick_cnt = '0;
                                phase    = PH_LOW;
                            end
                        end
                        PH_LOW:
                        begin
                            dur = floor_one(int'(bit_val ? one_low : zero_low));
                            tick_cnt++;
                            if (tick_cnt >= dur)
                            begin
                                tick_cnt = '0;
                                if (bit_pos > 0)
                                begin
                                    bit_pos--;
                                    phase = PH_HIGH;
                                end
                                else
                                begin
                                    led_pos = led_pos + 1'b1;
                                    if (led_pos < n)
                                        load_pixel();
                                    else
                                        phase = PH_LATCH;
                                end
                            end
                        end
                        PH_LATCH:
                        begin
                            tick_cnt++;
                            if (tick_cnt >= floor_one(int'(latch_len)))
                            begin
                                tick_cnt  = '0;
                                led_pos   = '0;
                                bit_pos   = '0;
                                phase     = PH_IDLE;
                                want.done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            want.busy = (prior != PH_IDLE) || (phase != PH_IDLE);
            pending_outputs.push_back(want);
        endfunction

        function void check_field(string what, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
                errors++;
            end
        endfunction

        function void compare_output(logic [31:0] data, logic last);
            strip_out_t want;
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual tdata %h tlast %b",
                         $time, data, last);
                errors++;
                return;
            end
            want = pending_outputs.pop_front();
            check_field("line_level", 32'(want.level), 32'(data[0]));
            check_field("busy", 32'(want.busy), 32'(data[1]));
            check_field("read_red", 32'(want.red), 32'(data[9:2]));
            check_field("read_green", 32'(want.green), 32'(data[17:10]));
            check_field("read_blue", 32'(want.blue), 32'(data[25:18]));
            check_field("tdata pad", 32'd0, 32'(data[31:26]));
            check_field("frame_done", 32'(want.done), 32'(last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [REG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    led_strip_scoreboard sb = new();
    bit                  no_idle = 1'b0;

    addressable_led_strip_driver #(
        .MAX_LEDS(MAX_PIXELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.compare_output(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #50000000;
        $display("** addressable_led_strip_driver: FAILED **");
        $finish;
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [7:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, g, r, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.accept_command(cmd, idx, r, g, b);
    endtask

    task automatic random_command();
        int               pick;
        int               lim;
        logic [CMD_W-1:0] cmd;
        logic [7:0]       idx;
        pick = $urandom_range(99);
        if (pick < 68)
            cmd = CMD_TICK;
        else if (pick < 80)
            cmd = CMD_SET_PIXEL;
        else if (pick < 88)
            cmd = CMD_READ;
        else if (pick < 95)
            cmd = CMD_START;
        else if (pick < 97)
            cmd = CMD_SET_ALL;
        else
            cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        lim = (sb.leds_used() + 1 > 255) ? 255 : sb.leds_used() + 1;
        if ($urandom_range(3) == 0)
            idx = 8'($urandom_range(255));
        else
            idx = 8'($urandom_range(lim));
        send_item(cmd, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // let the block drain before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(int count, int zh, int zl, int oh, int ol, int latch);
        logic [REG_DATA_W-1:0] vals [6];
        logic [REG_IDX_W-1:0]  idxs [6];
        idxs = '{REG_LED_COUNT, REG_ZERO_HIGH, REG_ZERO_LOW, REG_ONE_HIGH, REG_ONE_LOW,
                 REG_LATCH};
        vals = '{REG_DATA_W'(count), REG_DATA_W'(zh), REG_DATA_W'(zl), REG_DATA_W'(oh),
                 REG_DATA_W'(ol), REG_DATA_W'(latch)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int count, int zh, int zl, int oh, int ol, int latch, int items);
        settle();
        program_regs(count, zh, zl, oh, ol, latch);
        repeat (items) random_command();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        program_regs(4, 1, 2, 2, 1, 3);
        send_item(CMD_READ, 8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
        send_item(CMD_SET_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff);
        send_item(CMD_SET_PIXEL, 8'd3, 8'h00, 8'h80, 8'h01);
        send_item(CMD_SET_PIXEL, 8'd255, 8'hff, 8'hff, 8'hff);
        send_item(CMD_READ, 8'd255, 8'h00, 8'h00, 8'h00);
        send_item(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_SET_ALL, 8'd0, 8'h5a, 8'ha5, 8'h3c);
        send_item(CMD_READ, 8'd3, 8'h00, 8'h00, 8'h00);
        send_item(CMD_SET_PIXEL, 8'd1, 8'h80, 8'h01, 8'hfe);
        send_item(CMD_READ, 8'd1, 8'h00, 8'h00, 8'h00);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_item(CMD_W'(c), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_item(CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        // pixel 2 is fetched later in the frame, so the new color goes out
        send_item(CMD_SET_PIXEL, 8'd2, 8'hc3, 8'h3c, 8'h99);
        send_item(CMD_READ, 8'd2, 8'h00, 8'h00, 8'h00);
        repeat (4)
            send_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (200) random_command();

        run_phase(0, 2, 1, 1, 2, 1, 80);
        no_idle = 1'b1;
        run_phase(2, 0, 0, 0, 0, 0, 200);
        no_idle = 1'b0;
        run_phase(511, 255, 255, 255, 255, 65535, 120);
        run_phase(1, 1, 1, 1, 1, 1, 200);
        run_phase(256, 1, 1, 1, 1, 2, 120);
        run_phase($urandom_range(5, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                  $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(40, 1), 230);

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** addressable_led_strip_driver: PASSED **");
        else
            $display("** addressable_led_strip_driver: FAILED **");
        $finish;
    end

endmodule
